>>> src/sse_pkg.sv
// Shared types and constants for the substring search engine.
`default_nettype none
package sse_pkg;

   localparam int DEF_TEXT_DEPTH    = 4096;
   localparam int DEF_PATTERN_DEPTH = 64;
   localparam int QUEUE_DEPTH       = 4;
   localparam int BYTE_W            = 8;
   localparam int STATUS_W          = 2;
   localparam int OFFSET_W          = 12;

   typedef enum logic [1:0] {
      OP_PATTERN   = 2'd0,
      OP_TEXT      = 2'd1,
      OP_TEXT_LAST = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data;
   } q_entry_type;

endpackage
`default_nettype wire

>>> src/substring_search_engine.sv
// Top level: request queue front end feeding the search back end.
// Pattern and text bytes are queued and drain from the queue while the back end is idle.
// A final text byte starts a check step, then a memory read and a compare per byte compared,
// then a result step that waits for the result register to be free.
// Throughput: one byte per cycle into a four-entry queue; intake stalls while it is full.
// Reset clears counts, queue pointers and rsp_valid; the byte stores are not cleared.
`default_nettype none
module substring_search_engine #(
   parameter int TEXT_DEPTH    = sse_pkg::DEF_TEXT_DEPTH,
   parameter int PATTERN_DEPTH = sse_pkg::DEF_PATTERN_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_mode,
   input  wire [7:0]   req_data_byte,
   input  wire         req_last,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_match_offset
);
   import sse_pkg::*;

   logic        q_valid;
   q_entry_type q_entry;
   logic        q_pop;

   sse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   sse_back #(
      .TEXT_DEPTH    (TEXT_DEPTH),
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_match_offset (rsp_match_offset)
   );

endmodule
`default_nettype wire

>>> src/sse_front.sv
// Request intake: classifies each request and queues it for the search back end.
`default_nettype none
module sse_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_mode,
   input  wire [7:0]            req_data_byte,
   input  wire                  req_last,
   output logic                 q_valid,
   output sse_pkg::q_entry_type q_entry,
   input  wire                  q_pop
);
   import sse_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);

   q_entry_type          q_mem_ff [QUEUE_DEPTH];
   logic [QAW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]         count_ff, count_in;
   q_entry_type          new_entry;
   logic                 push;
   logic                 pop;

   always_comb begin
      new_entry.data = req_data_byte;
      if (!req_mode) begin
         new_entry.op = OP_PATTERN;
      end else if (req_last) begin
         new_entry.op = OP_TEXT_LAST;
      end else begin
         new_entry.op = OP_TEXT;
      end
   end

   assign req_stall = (count_ff == (QAW+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule
`default_nettype wire

>>> src/sse_back.sv
// Back end: stores pattern and text bytes and walks the search on the final text byte.
`default_nettype none
module sse_back #(
   parameter int TEXT_DEPTH    = sse_pkg::DEF_TEXT_DEPTH,
   parameter int PATTERN_DEPTH = sse_pkg::DEF_PATTERN_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_valid,
   input  sse_pkg::q_entry_type q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [11:0]          rsp_match_offset
);
   import sse_pkg::*;

   localparam int TAW  = $clog2(TEXT_DEPTH);
   localparam int PAW  = $clog2(PATTERN_DEPTH);
   localparam int TCW  = $clog2(TEXT_DEPTH + 1);
   localparam int PCW  = $clog2(PATTERN_DEPTH + 1);
   localparam int SUMW = ((TCW > PCW) ? TCW : PCW) + 1;
   localparam int EXW  = (SUMW > OFFSET_W) ? SUMW : OFFSET_W;

   logic [BYTE_W-1:0] text_mem [TEXT_DEPTH];
   logic [BYTE_W-1:0] pat_mem  [PATTERN_DEPTH];
   logic [BYTE_W-1:0] text_rd_ff;
   logic [BYTE_W-1:0] pat_rd_ff;

   state_type         state_ff, state_in;
   logic [PCW-1:0]    pc_ff, pc_in;
   logic [TCW-1:0]    tc_ff, tc_in;
   logic              ovf_ff, ovf_in;
   logic [SUMW-1:0]   off_ff, off_in;
   logic [SUMW-1:0]   span_ff, span_in;
   logic [PCW-1:0]    k_ff, k_in;
   status_type        res_ff, res_in;
   logic [SUMW-1:0]   pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;

   logic              pat_we;
   logic              text_we;
   logic              rsp_load;
   logic [SUMW-1:0]   addr_sum;
   logic [TAW-1:0]    text_addr;
   logic [PAW-1:0]    pat_addr;
   logic [PCW-1:0]    k_next;
   logic [EXW-1:0]    pos_ext;

   assign addr_sum  = off_ff + SUMW'(k_ff);
   assign text_addr = addr_sum[TAW-1:0];
   assign pat_addr  = k_ff[PAW-1:0];
   assign k_next    = k_ff + 1'b1;
   assign pos_ext   = EXW'(pos_ff);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      tc_in    = tc_ff;
      ovf_in   = ovf_ff;
      off_in   = off_ff;
      span_in  = span_ff;
      k_in     = k_ff;
      res_in   = res_ff;
      pos_in   = pos_ff;
      pat_we   = 1'b0;
      text_we  = 1'b0;
      q_pop    = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_entry.op)
                  OP_PATTERN: begin
                     if (pc_ff < PCW'(PATTERN_DEPTH)) begin
                        pat_we = 1'b1;
                        pc_in  = pc_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_TEXT, OP_TEXT_LAST: begin
                     if (tc_ff < TCW'(TEXT_DEPTH)) begin
                        text_we = 1'b1;
                        tc_in   = tc_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                     if (q_entry.op == OP_TEXT_LAST) begin
                        state_in = ST_CHECK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHECK: begin
            pos_in = '0;
            off_in = '0;
            k_in   = '0;
            span_in = SUMW'(tc_ff) - SUMW'(pc_ff);
            if (ovf_ff || (pc_ff < PCW'(2))) begin
               res_in   = STATUS_INVALID;
               state_in = ST_DONE;
            end else if (SUMW'(tc_ff) < SUMW'(pc_ff)) begin
               res_in   = STATUS_NOT_FOUND;
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // memory reads issue this cycle, compare next
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (text_rd_ff == pat_rd_ff) begin
               if (k_next >= pc_ff) begin
                  res_in   = STATUS_FOUND;
                  pos_in   = off_ff;
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_next;
                  state_in = ST_READ;
               end
            end else begin
               k_in = '0;
               if (off_ff == span_ff) begin
                  res_in   = STATUS_NOT_FOUND;
                  pos_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  off_in   = off_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               pc_in    = '0;
               tc_in    = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         tc_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         tc_ff        <= tc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff  <= off_in;
      span_ff <= span_in;
      k_ff    <= k_in;
      res_ff  <= res_in;
      pos_ff  <= pos_in;
      if (rsp_load) begin
         rsp_status_ff <= res_ff;
         rsp_offset_ff <= pos_ext[OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[tc_ff[TAW-1:0]] <= q_entry.data;
      end
      text_rd_ff <= text_mem[text_addr];
   end

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pc_ff[PAW-1:0]] <= q_entry.data;
      end
      pat_rd_ff <= pat_mem[pat_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule
`default_nettype wire
